// ===== hw/rtl/pits_pkg.sv =====
// Shared types, codes and helpers for the pin inject timed sequencer.
// Used by pits_ctrl, pits_datapath and pin_inject_timed_sequencer.
package pits_pkg;

   localparam int PIN_COUNT_DEF = 32;
   localparam int MAX_STEPS_DEF = 32;
   localparam int REQ_W         = 112;
   localparam int RSP_W         = 16;
   localparam int CSR_AW        = 4;

   typedef enum logic [2:0] {
      OP_SET     = 3'd0,
      OP_PULSE   = 3'd1,
      OP_RELEASE = 3'd2,
      OP_OPTIONS = 3'd3,
      OP_LOAD    = 3'd4,
      OP_PLAY    = 3'd5,
      OP_ABORT   = 3'd6,
      OP_TICK    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOTFOUND = 3'd1,
      ST_FORBID   = 3'd2,
      ST_NOTINJ   = 3'd3,
      ST_BADARGS  = 3'd4,
      ST_BUSY     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_DRIVE   = 2'd1,
      ACT_RELEASE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      REG_INJECTABLE = 2'd0,
      REG_FORBIDDEN  = 2'd1,
      REG_ANALOG     = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      SEL_REQ  = 2'd0,
      SEL_SCAN = 2'd1,
      SEL_STEP = 2'd2
   } rdsel_type;

   typedef struct packed {
      status_type status;
      logic [5:0] pin;
      action_type action;
      logic       level;
      logic [3:0] opts;   // bit0 open drain, 1 pull up, 2 pull down, 3 speed
   } res_type;

   typedef struct packed {
      rdsel_type rd_sel;
      logic      load_req;
      logic      exec_op;
      logic      scan_step;
      logic      seq_rd;
      logic      seq_drive;
      logic      seq_stop;
      logic      idle_emit;
      logic      flush;
   } dp_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic scan_hit;
      logic scan_last;
      logic seq_due;
      logic seq_end;
      logic pend_valid;
      logic out_free;
   } dp_stat_type;

   // deadline reached: signed difference now - deadline not negative
   function automatic logic is_due(logic [31:0] now, logic [31:0] dl);
      logic [31:0] d;
      d = now - dl;
      return ~d[31];
   endfunction

   // permission check; pins 32 and up have no mask bits
   function automatic status_type check_pin(logic [5:0] pin, logic [6:0] pin_count,
                                            logic [31:0] inj, logic [31:0] forb,
                                            logic [31:0] ana);
      if ({1'b0, pin} >= pin_count) return ST_NOTFOUND;
      if (!pin[5] && forb[pin[4:0]]) return ST_FORBID;
      if (pin[5] || !inj[pin[4:0]] || ana[pin[4:0]]) return ST_NOTINJ;
      return ST_OK;
   endfunction

endpackage

// ===== hw/rtl/pits_datapath.sv =====
// Datapath: config registers, pin timers, step memory, result buffers.
// Depends on pits_pkg; driven by pits_ctrl commands.
module pits_datapath import pits_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [REQ_W-1:0]  req_data,
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_wen,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat
);
   localparam int PIN_W  = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CNT_W  = $clog2(MAX_STEPS + 1);
   localparam logic [6:0] PC7 = 7'(PIN_COUNT);
   localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_STEPS);
   localparam logic [PIN_W-1:0] LASTP = PIN_W'(PIN_COUNT - 1);

   // config registers
   logic [31:0] inj_ff, forb_ff, ana_ff;
   reg_type     csr_idx;
   assign csr_idx = reg_type'(csr_paddr[3:2]);
   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ff  <= '0;
         forb_ff <= '0;
         ana_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_idx)
            REG_INJECTABLE: inj_ff  <= csr_pwdata;
            REG_FORBIDDEN:  forb_ff <= csr_pwdata;
            REG_ANALOG:     ana_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_idx)
         REG_INJECTABLE: csr_prdata = inj_ff;
         REG_FORBIDDEN:  csr_prdata = forb_ff;
         REG_ANALOG:     csr_prdata = ana_ff;
         default:        csr_prdata = '0;
      endcase
   end

   // latched request
   op_type      op_ff;
   logic [5:0]  pin_ff;
   logic        lvl_ff;
   logic [31:0] dur_ff, ms_ff, us_ff;
   logic [3:0]  opt_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= op_type'(req_data[2:0]);
         pin_ff <= req_data[8:3];
         lvl_ff <= req_data[9];
         dur_ff <= req_data[41:10];
         opt_ff <= req_data[45:42];
         ms_ff  <= req_data[77:46];
         us_ff  <= req_data[109:78];
      end
   end

   // pin state
   logic [PIN_COUNT-1:0] active_ff;
   logic [31:0]          hold_ff  [PIN_COUNT];
   logic [31:0]          pulse_ff [PIN_COUNT];
   logic [3:0]           opts_ff  [PIN_COUNT];
   logic [PIN_W-1:0]     scan_ff, scan_in;

   // sequencer state and step memory
   logic [CNT_W-1:0] count_ff, count_in, index_ff, index_in;
   logic             run_ff, run_in;
   logic [31:0]      sdl_ff, sdl_in;
   logic [5:0]       mem_pin   [MAX_STEPS];
   logic             mem_lvl   [MAX_STEPS];
   logic [31:0]      mem_delay [MAX_STEPS];
   logic [5:0]       rd_pin;
   logic             rd_lvl;
   logic [31:0]      rd_delay;

   // result buffers: one pending, one output
   res_type pend_ff, out_ff;
   logic    pend_v_ff, out_v_ff, out_last_ff;

   logic [5:0]       cur_pin;
   logic [PIN_W-1:0] rd_idx;
   logic             in_range, active_rd, hit;
   logic [31:0]      hold_rd, pulse_rd;
   logic [3:0]       opt_rd;
   status_type       chk, stl;
   logic             pw_en, pw_act, opt_wen, mem_wen, cap_en;
   logic [31:0]      pw_hold, pw_pulse;
   res_type          res;

   // single read port of the pin arrays, address chosen by state
   always_comb begin
      case (cmd.rd_sel)
         SEL_SCAN: cur_pin = 6'(scan_ff);
         SEL_STEP: cur_pin = rd_pin;
         default:  cur_pin = pin_ff;
      endcase
   end
   assign rd_idx    = cur_pin[PIN_W-1:0];
   assign in_range  = ({1'b0, cur_pin} < PC7);
   assign active_rd = in_range & active_ff[rd_idx];
   assign hold_rd   = hold_ff[rd_idx];
   assign pulse_rd  = pulse_ff[rd_idx];
   assign opt_rd    = in_range ? opts_ff[rd_idx] : 4'd0;
   assign chk       = check_pin(cur_pin, PC7, inj_ff, forb_ff, ana_ff);
   assign hit = active_rd &&
                ((pulse_rd != 32'd0 && is_due(us_ff, pulse_rd)) ||
                 (hold_rd != 32'd0 && is_due(ms_ff, hold_rd)));

   // next state for every command
   always_comb begin
      scan_in  = scan_ff;
      count_in = count_ff;
      index_in = index_ff;
      run_in   = run_ff;
      sdl_in   = sdl_ff;
      pw_en    = 1'b0;
      pw_act   = 1'b0;
      pw_hold  = '0;
      pw_pulse = '0;
      opt_wen  = 1'b0;
      mem_wen  = 1'b0;
      cap_en   = 1'b0;
      res      = '0;
      stl      = ST_OK;
      if (cmd.load_req) scan_in = '0;
      if (cmd.exec_op) begin
         cap_en = 1'b1;
         case (op_ff)
            OP_SET, OP_PULSE: begin
               res.pin    = pin_ff;
               res.status = chk;
               if (chk == ST_OK) begin
                  pw_en      = 1'b1;
                  pw_act     = 1'b1;
                  res.action = ACT_DRIVE;
                  res.opts   = opt_rd;
                  if (op_ff == OP_PULSE) begin
                     pw_pulse  = us_ff + dur_ff;
                     res.level = 1'b1;
                  end else begin
                     pw_hold   = (dur_ff != 32'd0) ? ms_ff + dur_ff : 32'd0;
                     res.level = lvl_ff;
                  end
               end
            end
            OP_RELEASE: begin
               res.pin = pin_ff;
               if (!in_range) begin
                  res.status = ST_NOTFOUND;
               end else begin
                  pw_en      = 1'b1;
                  res.action = ACT_RELEASE;
                  res.opts   = opt_rd;
               end
            end
            OP_OPTIONS: begin
               res.pin    = pin_ff;
               res.status = chk;
               if (chk == ST_OK) begin
                  opt_wen  = 1'b1;
                  res.opts = opt_ff;
               end
            end
            OP_LOAD: begin
               if (run_ff)                stl = ST_BUSY;
               else if (count_ff >= MAXC) stl = ST_BADARGS;
               else                       stl = chk;
               if (stl == ST_OK) begin
                  mem_wen  = 1'b1;
                  count_in = count_ff + 1'b1;
               end else if (stl != ST_BUSY) begin
                  count_in = '0;
               end
               res.status = stl;
            end
            OP_PLAY: begin
               if (run_ff) begin
                  res.status = ST_BUSY;
               end else if (count_ff == '0) begin
                  res.status = ST_BADARGS;
               end else begin
                  index_in = '0;
                  run_in   = 1'b1;
                  sdl_in   = us_ff;
               end
            end
            OP_ABORT: begin
               run_in   = 1'b0;
               count_in = '0;
               index_in = '0;
               sdl_in   = '0;
            end
            default: cap_en = 1'b0;
         endcase
      end
      // one pin timer a cycle, held while a hit has no room for its result
      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         if (hit) begin
            pw_en      = 1'b1;
            cap_en     = 1'b1;
            res.pin    = cur_pin;
            res.action = ACT_RELEASE;
            res.opts   = opt_rd;
         end
      end
      if (cmd.seq_stop) begin
         run_in   = 1'b0;
         count_in = '0;
         index_in = '0;
      end
      // sequence step: set with no hold
      if (cmd.seq_drive) begin
         cap_en     = 1'b1;
         res.pin    = cur_pin;
         res.status = chk;
         if (chk == ST_OK) begin
            pw_en      = 1'b1;
            pw_act     = 1'b1;
            res.action = ACT_DRIVE;
            res.level  = rd_lvl;
            res.opts   = opt_rd;
         end
         sdl_in   = us_ff + rd_delay;
         index_in = index_ff + 1'b1;
      end
      if (cmd.idle_emit) cap_en = 1'b1;
   end

   // pin state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < PIN_COUNT; i++) opts_ff[i] <= '0;
      end else begin
         if (pw_en) begin
            active_ff[rd_idx] <= pw_act;
            hold_ff[rd_idx]   <= pw_hold;
            pulse_ff[rd_idx]  <= pw_pulse;
         end
         if (opt_wen) opts_ff[rd_idx] <= opt_ff;
      end
   end

   // step memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wen) begin
         mem_pin[count_ff[ADDR_W-1:0]]   <= pin_ff;
         mem_lvl[count_ff[ADDR_W-1:0]]   <= lvl_ff;
         mem_delay[count_ff[ADDR_W-1:0]] <= (dur_ff != 32'd0) ? dur_ff : 32'd1;
      end
      if (cmd.seq_rd) begin
         rd_pin   <= mem_pin[index_ff[ADDR_W-1:0]];
         rd_lvl   <= mem_lvl[index_ff[ADDR_W-1:0]];
         rd_delay <= mem_delay[index_ff[ADDR_W-1:0]];
      end
   end

   // sequencer and scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
         run_ff   <= 1'b0;
         sdl_ff   <= '0;
      end else begin
         scan_ff  <= scan_in;
         count_ff <= count_in;
         index_ff <= index_in;
         run_ff   <= run_in;
         sdl_ff   <= sdl_in;
      end
   end

   // pending and output result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         if (cap_en) begin
            pend_ff   <= res;
            pend_v_ff <= 1'b1;
            if (pend_v_ff) begin
               out_ff      <= pend_ff;
               out_last_ff <= 1'b0;
               out_v_ff    <= 1'b1;
            end
         end else if (cmd.flush) begin
            out_ff      <= pend_ff;
            out_last_ff <= 1'b1;
            out_v_ff    <= 1'b1;
            pend_v_ff   <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_ff.opts, out_ff.level, out_ff.action, out_ff.pin, out_ff.status};

   assign stat.is_tick    = (op_ff == OP_TICK);
   assign stat.scan_hit   = hit;
   assign stat.scan_last  = (scan_ff == LASTP);
   assign stat.seq_due    = run_ff && is_due(us_ff, sdl_ff);
   assign stat.seq_end    = (index_ff >= count_ff);
   assign stat.pend_valid = pend_v_ff;
   assign stat.out_free   = !out_v_ff || rsp_tready;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cap_en && pend_v_ff) |-> (!out_v_ff || rsp_tready))
      else $error("pending result pushed onto a full output");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAXC)
      else $error("step count beyond step memory");
   a_index_run: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (index_ff <= count_ff))
      else $error("step index past step count while running");
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.flush && !cap_en) |=> !pend_v_ff && out_v_ff && out_last_ff)
      else $error("flush did not close the request");
`endif

endmodule

// ===== hw/rtl/pits_ctrl.sv =====
// Controller state machine: sequences decode, pin scan, step fire, flush.
// Depends on pits_pkg; talks to pits_datapath by command and status.
module pits_ctrl import pits_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);
   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_SCAN, S_SEQCHK, S_SEQRD, S_FIN, S_FLUSH
   } state_type;

   state_type state_ff, state_in;
   logic      room;

   // a capture is safe when the pending slot can move on
   assign room = !stat.pend_valid || stat.out_free;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.rd_sel = SEL_REQ;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.rd_sel = SEL_REQ;
            if (stat.is_tick) begin
               state_in = S_SCAN;
            end else begin
               cmd.exec_op = 1'b1;
               state_in    = S_FLUSH;
            end
         end
         S_SCAN: begin
            cmd.rd_sel = SEL_SCAN;
            if (!stat.scan_hit || room) begin
               cmd.scan_step = 1'b1;
               if (stat.scan_last) state_in = S_SEQCHK;
            end
         end
         S_SEQCHK: begin
            cmd.rd_sel = SEL_REQ;
            if (!stat.seq_due) begin
               state_in = S_FIN;
            end else if (stat.seq_end) begin
               cmd.seq_stop = 1'b1;
               state_in     = S_FIN;
            end else begin
               cmd.seq_rd = 1'b1;
               state_in   = S_SEQRD;
            end
         end
         S_SEQRD: begin
            cmd.rd_sel = SEL_STEP;
            if (room) begin
               cmd.seq_drive = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            cmd.rd_sel = SEL_REQ;
            if (!stat.pend_valid) cmd.idle_emit = 1'b1;
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            cmd.rd_sel = SEL_REQ;
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/pin_inject_timed_sequencer.sv =====
// Top level: pin drive injector with timed release and step sequencer.
// Depends on pits_pkg, pits_ctrl, pits_datapath.
//
//   port group | direction | content
//   req_*      | in        | one operation request with current ms/us time
//   rsp_*      | out       | one to PIN_COUNT+1 results, tlast on the final one
//   csr_*      | in/out    | permission mask registers
//
// Non-tick ops pass through load, execute and flush, held by output stalls.
// A tick walks all pin timers one per cycle, held while a hit has no room,
// then checks, reads and fires a due sequence step, and flushes.
// Synchronous active-high reset clears masks, pin state and sequencer.
// A stalled rsp side holds the pin scan; requests wait until done.
module pin_inject_timed_sequencer import pits_pkg::*; #(
   parameter int PIN_COUNT = PIN_COUNT_DEF,
   parameter int MAX_STEPS = MAX_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // op[2:0] pin[8:3] level[9] duration[41:10] drv_od[42] pull_up[43]
   // pull_lo[44] fast_slew[45] now_ms[77:46] now_us[109:78] zero[111:110]
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status[2:0] pin_out[8:3] action[10:9] drive_level[11] out_drv_od[12]
   // out_pull_up[13] out_pull_lo[14] out_fast_slew[15]
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_wen;

   assign csr_pready = 1'b1;
   assign csr_wen    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   pits_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   pits_datapath #(
      .PIN_COUNT (PIN_COUNT),
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
